@@ rtl/core/asga_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package asga_pkg;

  localparam int CHANNELS_DEF      = 4;
  localparam int SAMPLE_BITS_DEF   = 12;
  localparam int MAX_AVG_COUNT_DEF = 64;

  localparam int CH_BITS           = 2;
  localparam int CFG_REGS_PER_KIND = 4;
  localparam int WINDOW_BITS       = 12;
  localparam int AVG_COUNT_BITS    = 7;
  localparam int CFG_INDEX_BITS    = 3;
  localparam int CFG_DATA_BITS     = 12;

  localparam logic [CFG_INDEX_BITS-1:0] REG_AVG_COUNT_CH0 = 3'd4;

  localparam logic [WINDOW_BITS-1:0]    WINDOW_RESET    = 12'd50;
  localparam logic [AVG_COUNT_BITS-1:0] AVG_COUNT_RESET = 7'd8;

  typedef struct packed {
    logic load;
    logic div_start;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/asga_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module asga_div #(
  parameter int DIVIDEND_BITS = 18,
  parameter int DIVISOR_BITS  = 7
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [DIVIDEND_BITS-1:0] dividend,
  input  wire logic [DIVISOR_BITS-1:0]  divisor,
  output logic      [DIVIDEND_BITS-1:0] quotient,
  output logic                          done
);

  localparam int STEP_BITS = $clog2(DIVIDEND_BITS + 1);

  logic [DIVIDEND_BITS-1:0] quo;
  logic [DIVISOR_BITS-1:0]  rem;
  logic [STEP_BITS-1:0]     steps;
  logic [DIVISOR_BITS:0]    rem_sh;
  logic [DIVISOR_BITS:0]    trial;
  logic                     ge;

  assign rem_sh = {rem, quo[DIVIDEND_BITS-1]};
  assign ge     = rem_sh >= {1'b0, divisor};
  assign trial  = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= STEP_BITS'(DIVIDEND_BITS);
    end else if (steps != '0) begin
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (steps != '0) begin
      rem <= ge ? trial[DIVISOR_BITS-1:0] : rem_sh[DIVISOR_BITS-1:0];
      quo <= {quo[DIVIDEND_BITS-2:0], ge};
    end
  end

  assign quotient = quo;
  assign done     = (steps == '0);

endmodule

`default_nettype wire

@@ rtl/core/asga_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module asga_datapath #(
  parameter int CHANNELS      = asga_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS   = asga_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_AVG_COUNT = asga_pkg::MAX_AVG_COUNT_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire asga_pkg::ctrl_cmd_t                  cmd,
  output asga_pkg::dp_status_t                      status,
  input  wire logic                                 cfg_write,
  input  wire logic [asga_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [asga_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  wire logic [asga_pkg::CH_BITS-1:0]         channel,
  input  wire logic [SAMPLE_BITS-1:0]               sample,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic      [asga_pkg::CH_BITS-1:0]         out_channel,
  output logic      [SAMPLE_BITS-1:0]               filtered_value,
  output logic                                      filtered_valid,
  output logic                                      new_average
);

  localparam int CH_IDX   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_BITS = $clog2(MAX_AVG_COUNT + 1);
  localparam int SUM_BITS = SAMPLE_BITS + ((MAX_AVG_COUNT > 1) ? $clog2(MAX_AVG_COUNT) : 0);
  localparam int CMP_BITS = (SAMPLE_BITS > asga_pkg::WINDOW_BITS) ? SAMPLE_BITS
                                                                  : asga_pkg::WINDOW_BITS;
  localparam logic [SUM_BITS-1:0] SAT_LIMIT = SUM_BITS'((64'd1 << SAMPLE_BITS) - 64'd1);

  logic [asga_pkg::WINDOW_BITS-1:0]    window_cfg [asga_pkg::CFG_REGS_PER_KIND];
  logic [asga_pkg::AVG_COUNT_BITS-1:0] count_cfg  [asga_pkg::CFG_REGS_PER_KIND];

  logic [SAMPLE_BITS-1:0] previous_sample [CHANNELS];
  logic [SUM_BITS-1:0]    running_sum     [CHANNELS];
  logic [CNT_BITS-1:0]    stable_count    [CHANNELS];
  logic [SAMPLE_BITS-1:0] average_value   [CHANNELS];
  logic [CHANNELS-1:0]    average_valid;

  logic [asga_pkg::CH_BITS-1:0]     ch_r;
  logic [CH_IDX-1:0]                idx_r;
  logic                             oor_r;
  logic [SAMPLE_BITS-1:0]           s_r;
  logic [SAMPLE_BITS-1:0]           prev_r;
  logic [SUM_BITS-1:0]              sum_r;
  logic [CNT_BITS-1:0]              cnt_r;
  logic [asga_pkg::WINDOW_BITS-1:0] win_r;
  logic [CNT_BITS-1:0]              n_r;

  logic [CH_IDX-1:0]                   in_idx;
  logic                                in_oor;
  logic [asga_pkg::AVG_COUNT_BITS-1:0] in_cfg_count;
  logic [CNT_BITS-1:0]                 in_n;
  logic [SAMPLE_BITS-1:0]              diff;
  logic                                stable;
  logic                                full;
  logic [SUM_BITS-1:0]                 quotient;
  logic                                div_done;
  logic [SAMPLE_BITS-1:0]              q_sat;

  assign in_idx       = channel[CH_IDX-1:0];
  assign in_oor       = 32'(channel) >= CHANNELS;
  assign in_cfg_count = count_cfg[channel];

  always_comb begin
    if (in_cfg_count == '0) begin
      in_n = CNT_BITS'(1);
    end else if (int'(in_cfg_count) > MAX_AVG_COUNT) begin
      in_n = CNT_BITS'(MAX_AVG_COUNT);
    end else begin
      in_n = CNT_BITS'(in_cfg_count);
    end
  end

  assign diff   = (s_r >= prev_r) ? (s_r - prev_r) : (prev_r - s_r);
  assign stable = CMP_BITS'(diff) < CMP_BITS'(win_r);
  assign full   = cnt_r >= n_r;
  assign q_sat  = (quotient > SAT_LIMIT) ? '1 : quotient[SAMPLE_BITS-1:0];

  assign status.need_div = !oor_r && stable && full;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;

  asga_div #(
    .DIVIDEND_BITS(SUM_BITS),
    .DIVISOR_BITS (CNT_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(sum_r),
    .divisor (n_r),
    .quotient(quotient),
    .done    (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < asga_pkg::CFG_REGS_PER_KIND; i++) begin
        window_cfg[i] <= asga_pkg::WINDOW_RESET;
        count_cfg[i]  <= asga_pkg::AVG_COUNT_RESET;
      end
    end else if (cfg_write) begin
      if (cfg_index < asga_pkg::REG_AVG_COUNT_CH0) begin
        window_cfg[cfg_index[asga_pkg::CH_BITS-1:0]] <= cfg_data[asga_pkg::WINDOW_BITS-1:0];
      end else begin
        count_cfg[cfg_index[asga_pkg::CH_BITS-1:0]] <= cfg_data[asga_pkg::AVG_COUNT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r   <= channel;
      idx_r  <= in_idx;
      oor_r  <= in_oor;
      s_r    <= sample;
      prev_r <= in_oor ? '0 : previous_sample[in_idx];
      sum_r  <= in_oor ? '0 : running_sum[in_idx];
      cnt_r  <= in_oor ? '0 : stable_count[in_idx];
      win_r  <= window_cfg[channel];
      n_r    <= in_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        previous_sample[i] <= '0;
        running_sum[i]     <= '0;
        stable_count[i]    <= '0;
        average_value[i]   <= '0;
      end
      average_valid <= '0;
    end else if (cmd.commit && !oor_r) begin
      previous_sample[idx_r] <= s_r;
      if (stable && full) begin
        average_value[idx_r] <= q_sat;
        running_sum[idx_r]   <= '0;
        stable_count[idx_r]  <= '0;
        average_valid[idx_r] <= 1'b1;
      end else if (stable) begin
        running_sum[idx_r]  <= sum_r + SUM_BITS'(s_r);
        stable_count[idx_r] <= cnt_r + 1'b1;
      end else begin
        running_sum[idx_r]   <= '0;
        stable_count[idx_r]  <= '0;
        average_valid[idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_channel <= ch_r;
      if (oor_r) begin
        filtered_value <= '0;
        filtered_valid <= 1'b0;
        new_average    <= 1'b0;
      end else if (stable && full) begin
        filtered_value <= q_sat;
        filtered_valid <= 1'b1;
        new_average    <= 1'b1;
      end else begin
        filtered_value <= average_value[idx_r];
        filtered_valid <= stable && average_valid[idx_r];
        new_average    <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/asga_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module asga_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire asga_pkg::dp_status_t status,
  output asga_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [1:0] {
    IDLE,
    EVAL,
    DIVIDE,
    COMMIT
  } state_t;

  state_t state;

  assign cmd.load      = in_valid && in_ready;
  assign cmd.div_start = (state == EVAL) && status.need_div;
  assign cmd.commit    = (state == COMMIT) && status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      in_ready <= 1'b1;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            state    <= EVAL;
            in_ready <= 1'b0;
          end
        end
        EVAL: begin
          state <= status.need_div ? DIVIDE : COMMIT;
        end
        DIVIDE: begin
          if (status.div_done) begin
            state <= COMMIT;
          end
        end
        COMMIT: begin
          if (status.out_free) begin
            state    <= IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/adc_stability_gated_averager_core.sv @@
// Channel  Direction  Handshake                 Payload
// input    in         in_valid / in_ready       channel, sample
// output   out        out_valid / out_ready     out_channel, filtered_value,
//                                               filtered_valid, new_average
// config   in         cfg_write                 cfg_index, cfg_data
//
// A sample that does not complete an average passes through the EVAL and COMMIT states after accept.
// A completing sample also passes through the DIVIDE state, which waits for the
// one-bit-per-cycle restoring divider.
// One transaction is in work at a time; the next is accepted while a result waits.
// Reset is synchronous; it restores the configuration defaults and clears all channel state.
// A stalled output holds the finished item in the commit step until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module adc_stability_gated_averager_core #(
  parameter int CHANNELS      = asga_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS   = asga_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_AVG_COUNT = asga_pkg::MAX_AVG_COUNT_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [asga_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [asga_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [asga_pkg::CH_BITS-1:0]        channel,
  input  wire logic [SAMPLE_BITS-1:0]              sample,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [asga_pkg::CH_BITS-1:0]        out_channel,
  output logic      [SAMPLE_BITS-1:0]              filtered_value,
  output logic                                     filtered_valid,
  output logic                                     new_average
);

  asga_pkg::ctrl_cmd_t  cmd;
  asga_pkg::dp_status_t status;

  asga_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  asga_datapath #(
    .CHANNELS     (CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .MAX_AVG_COUNT(MAX_AVG_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .channel       (channel),
    .sample        (sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_channel   (out_channel),
    .filtered_value(filtered_value),
    .filtered_valid(filtered_valid),
    .new_average   (new_average)
  );

endmodule

`default_nettype wire

@@ rtl/core/asga_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module asga_checker #(
  parameter int SAMPLE_BITS = asga_pkg::SAMPLE_BITS_DEF
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [asga_pkg::CH_BITS-1:0] out_channel,
  input wire logic [SAMPLE_BITS-1:0]       filtered_value,
  input wire logic                         filtered_valid,
  input wire logic                         new_average
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output valid after reset.");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Second transaction accepted while one is in work.");

  a_fresh_is_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_average |-> filtered_valid)
    else $error("Fresh average reported without valid flag.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_channel)
      && $stable(filtered_value) && $stable(filtered_valid) && $stable(new_average))
    else $error("Stalled result changed.");

endmodule

bind adc_stability_gated_averager_core asga_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_asga_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_channel   (out_channel),
  .filtered_value(filtered_value),
  .filtered_valid(filtered_valid),
  .new_average   (new_average)
);

`default_nettype wire
